### rtl/icl_pkg.sv
// ----------------------------------------------------------------------------
// icl_pkg: shared types and constants for the interval chain length block
// Widths of the payload fields, the default table depth and the structs
// that travel between the top level, the chain and its cells.
// ----------------------------------------------------------------------------
package icl_pkg;

  // Payload widths.
  localparam int unsigned CenterW    = 32;
  localparam int unsigned HalfWidthW = 31;
  localparam int unsigned LenW       = 9;

  // Interval ends span center +/- half width and need one extra bit; two are kept.
  localparam int unsigned EndW = 34;

  // Default number of chain lengths held in the table.
  localparam int unsigned MaxChainDef = 256;

  // End value that every interval's left end is at or above.
  localparam logic signed [EndW-1:0] EndMin = {1'b1, {(EndW-1){1'b0}}};

  // Values broadcast from the top level to every cell at once.
  typedef struct packed {
    logic                   upd;
    logic                   clr;
    logic signed [EndW-1:0] left;
    logic signed [EndW-1:0] right;
  } icl_bcast_t;

  // Old entry that a cell hands to its right neighbor.
  typedef struct packed {
    logic                   valid;
    logic signed [EndW-1:0] end_val;
  } icl_link_t;

endpackage

### rtl/icl_if.sv
// ----------------------------------------------------------------------------
// icl_if: valid/ready channels of the interval chain length block
// One interface for the interval input and one for the result output.
// ----------------------------------------------------------------------------
interface icl_in_if
  import icl_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic                         start_req;
  logic signed [CenterW-1:0]    center;
  logic        [HalfWidthW-1:0] half_width;

  modport source (output valid, output start_req, output center, output half_width,
                  input ready);
  modport sink   (input valid, input start_req, input center, input half_width,
                  output ready);
endinterface

interface icl_out_if
  import icl_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [LenW-1:0] chain_length;
  logic            capacity_hit;

  modport source (output valid, output chain_length, output capacity_hit, input ready);
  modport sink   (input valid, input chain_length, input capacity_hit, output ready);
endinterface

### rtl/interval_chain_length_dp.sv
// ----------------------------------------------------------------------------
// interval_chain_length_dp: longest chain of disjoint intervals
// Keeps the smallest right end for every chain length in a row of cells and
// reports the longest chain after each interval.
//
//   Channel | Dir | Payload                              | Transfer
//   in_i    | in  | start_req, center, half_width        | valid & ready
//   out_o   | out | chain_length, capacity_hit           | valid & ready
//
// One interval per cycle is taken while the output is not stalled; the end
// stage registers the interval ends, and from it all cells are updated at
// once and the output register is loaded.
// Reset empties the table and clears the capacity flag; no clearing pass.
// A stalled output holds the result and, once the end stage is full, the input.
// ----------------------------------------------------------------------------
module interval_chain_length_dp
  import icl_pkg::*;
#(
  parameter int unsigned MaxChain = MaxChainDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  icl_in_if.sink    in_i,
  icl_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(MaxChain + 1);

  logic                   s1_valid_q;
  logic                   s1_start_q;
  logic signed [EndW-1:0] s1_left_q, s1_right_q;
  logic                   out_valid_q;
  logic [LenW-1:0]        len_q;
  logic                   cap_q;
  logic                   out_free;
  logic                   advance;
  logic                   in_xfer;
  logic signed [EndW-1:0] center_ext, half_ext;
  icl_bcast_t             bcast;
  logic [CntW-1:0]        count;
  logic                   cap;
  logic [CntW+LenW-1:0]   count_wide;

  // Handshake between the end stage and the output register.
  assign out_free   = ~out_valid_q | out_o.ready;
  assign advance    = s1_valid_q & out_free;
  assign in_i.ready = ~s1_valid_q | out_free;
  assign in_xfer    = in_i.valid & in_i.ready;

  // Interval ends, sign and zero extended to the end width.
  assign center_ext = EndW'(in_i.center);
  assign half_ext   = EndW'({1'b0, in_i.half_width});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_start_q <= in_i.start_req;
      s1_left_q  <= center_ext - half_ext;
      s1_right_q <= center_ext + half_ext;
    end
  end

  // Broadcast of the staged interval to the cell row.
  assign bcast.upd   = advance;
  assign bcast.clr   = s1_start_q;
  assign bcast.left  = s1_left_q;
  assign bcast.right = s1_right_q;

  icl_chain #(
    .MaxChain (MaxChain)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bcast_i (bcast),
    .count_o (count),
    .cap_o   (cap)
  );

  // The reported length keeps its low bits only.
  assign count_wide = (CntW + LenW)'(count);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      len_q <= count_wide[LenW-1:0];
      cap_q <= cap;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.chain_length = len_q;
  assign out_o.capacity_hit = cap_q;

endmodule

### rtl/icl_cell.sv
// ----------------------------------------------------------------------------
// icl_cell: one entry of the minimum end table
// Holds the smallest right end of a chain of one fixed length and lowers it
// when the broadcast interval extends the neighbor's chain.
// ----------------------------------------------------------------------------
module icl_cell
  import icl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  icl_bcast_t bcast_i,
  input  icl_link_t  prev_i,
  output icl_link_t  next_o,
  output logic       grow_o
);

  logic                   valid_q, valid_d;
  logic signed [EndW-1:0] end_q, end_d;
  logic                   old_valid;
  logic                   take;

  // A start clears the entry before the interval is applied.
  assign old_valid = valid_q & ~bcast_i.clr;

  // Extend the neighbor's chain if that lowers this entry.
  assign take = prev_i.valid && (prev_i.end_val <= bcast_i.left) &&
                (!old_valid || (bcast_i.right < end_q));

  always_comb begin
    valid_d = valid_q;
    end_d   = end_q;
    if (bcast_i.upd) begin
      valid_d = old_valid | take;
      if (take) begin
        end_d = bcast_i.right;
      end
    end
  end

  // The old entry goes to the right neighbor.
  assign next_o.valid   = old_valid;
  assign next_o.end_val = end_q;
  assign grow_o         = bcast_i.upd & take & ~old_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q <= end_d;
  end

endmodule

### rtl/icl_chain.sv
// ----------------------------------------------------------------------------
// icl_chain: row of table cells with the length count and capacity flag
// Valid entries always form a prefix, so the longest length grows by one
// whenever any cell becomes valid.
// ----------------------------------------------------------------------------
module icl_chain
  import icl_pkg::*;
#(
  parameter int unsigned MaxChain = MaxChainDef,
  localparam int unsigned CntW    = $clog2(MaxChain + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  icl_bcast_t      bcast_i,
  output logic [CntW-1:0] count_o,
  output logic            cap_o
);

  icl_link_t            link [MaxChain+1];
  logic [MaxChain-1:0]  grow;
  logic [CntW-1:0]      count_q, count_d;
  logic                 cap_q, cap_d;

  // Length zero is always valid with an end below every left end.
  assign link[0].valid   = 1'b1;
  assign link[0].end_val = EndMin;

  // Row of cells, each seeing its left neighbor's old entry.
  for (genvar i = 0; i < MaxChain; i++) begin : g_cell
    icl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bcast_i (bcast_i),
      .prev_i  (link[i]),
      .next_o  (link[i+1]),
      .grow_o  (grow[i])
    );
  end

  // Count and sticky overflow flag, both cleared by a start.
  always_comb begin
    count_d = count_q;
    cap_d   = cap_q;
    if (bcast_i.upd) begin
      count_d = (bcast_i.clr ? '0 : count_q) + CntW'(|grow);
      cap_d   = (cap_q & ~bcast_i.clr) |
                (link[MaxChain].valid && (link[MaxChain].end_val <= bcast_i.left));
    end
  end

  assign count_o = count_d;
  assign cap_o   = cap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

endmodule

### dv/icl_chain_checker.sv
// ----------------------------------------------------------------------------
// icl_chain_checker: result predictor and scoreboard for the chain length block
// Watches the interval and result channels. Every accepted interval is run
// through a cycle-free copy of the end table to form the expected result, and
// every accepted result is compared in order against those expectations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icl_chain_checker
  import icl_pkg::*;
#(
  parameter int unsigned Depth = MaxChainDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  icl_in_if         in_mon,
  icl_out_if        out_mon,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o,
  output int        cap_seen_o
);

  typedef struct packed {
    logic [LenW-1:0] chain_length;
    logic            capacity_hit;
  } chain_result_t;

  // Smallest right end per chain length, its valid bit and the sticky flag.
  longint        min_end[Depth];
  bit            end_valid[Depth];
  bit            cap_sticky;
  chain_result_t expected_q[$];

  function automatic void clear_ends();
    for (int k = 0; k < Depth; k++) begin
      min_end[k]   = 0;
      end_valid[k] = 1'b0;
    end
    cap_sticky = 1'b0;
  endfunction

  // Applies one interval to the table and returns the longest chain.
  // Lengths are walked from the top down so that every cell still sees
  // its neighbor's old entry, as in the hardware update of all cells at once.
  function automatic chain_result_t predict_chain(bit start, logic signed [CenterW-1:0] center,
                                                  logic [HalfWidthW-1:0] half_width);
    longint        lo;
    longint        hi;
    int unsigned   longest;
    chain_result_t res;
    lo = longint'(center) - longint'(half_width);
    hi = longint'(center) + longint'(half_width);
    if (start) begin
      clear_ends();
    end
    // A chain one longer than the table holds is dropped but remembered.
    if (end_valid[Depth-1] && min_end[Depth-1] <= lo) begin
      cap_sticky = 1'b1;
    end
    for (int k = Depth - 1; k >= 1; k--) begin
      if (end_valid[k-1] && min_end[k-1] <= lo && (!end_valid[k] || hi < min_end[k])) begin
        min_end[k]   = hi;
        end_valid[k] = 1'b1;
      end
    end
    // Length one extends the empty chain, which always fits.
    if (!end_valid[0] || hi < min_end[0]) begin
      min_end[0]   = hi;
      end_valid[0] = 1'b1;
    end
    longest = 0;
    for (int k = 0; k < Depth; k++) begin
      if (end_valid[k]) begin
        longest = k + 1;
      end
    end
    res.chain_length = longest[LenW-1:0];
    res.capacity_hit = cap_sticky;
    return res;
  endfunction

  // Results are checked before the new interval is queued; the block's
  // latency means a result never belongs to an interval of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    chain_result_t want;
    if (!rst_ni) begin
      clear_ends();
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no interval outstanding: chain_length %0d",
                 out_mon.chain_length);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (out_mon.capacity_hit === 1'b1) begin
            cap_seen_o++;
          end
          if (out_mon.chain_length !== want.chain_length) begin
            $error("chain_length mismatch: expected %0d, actual %0d",
                   want.chain_length, out_mon.chain_length);
            fail_count_o++;
          end
          if (out_mon.capacity_hit !== want.capacity_hit) begin
            $error("capacity_hit mismatch: expected %0b, actual %0b",
                   want.capacity_hit, out_mon.capacity_hit);
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(predict_chain(in_mon.start_req, in_mon.center,
                                           in_mon.half_width));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the interval chain length block
// Drives directed corner intervals and then random interval sequences, most
// of them ascending chains with random widths and a few that overflow the
// table, under three mixes of sender and receiver stalls. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import icl_pkg::*;

  localparam int unsigned MaxChain = MaxChainDef;
  localparam longint      CenterMin = -(64'sd1 <<< (CenterW - 1));
  localparam longint      CenterMax = (64'sd1 <<< (CenterW - 1)) - 1;
  localparam longint      HalfMax   = (64'sd1 <<< HalfWidthW) - 1;

  logic clk_i;
  logic rst_ni;

  icl_in_if  in_if ();
  icl_out_if out_if ();

  int fail_count;
  int pending;
  int checked;
  int cap_seen;

  int     src_idle_pct;
  int     snk_idle_pct;
  int     sent;
  int     starts;
  longint cur_center;

  interval_chain_length_dp #(
    .MaxChain(MaxChain)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  icl_chain_checker #(
    .Depth(MaxChain)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .cap_seen_o  (cap_seen)
  );

  // 50 MHz clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Offers one interval after a random idle gap and holds it until its transfer.
  task automatic send_interval(bit start, longint center, longint half_width);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.start_req  <= start;
    in_if.center     <= center[CenterW-1:0];
    in_if.half_width <= half_width[HalfWidthW-1:0];
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    sent++;
    if (start) begin
      starts++;
    end
  endtask

  // Stops offering intervals until every outstanding result has arrived.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sends an ascending run of intervals. A tight run keeps each interval
  // disjoint from or touching the previous one, so the chain keeps growing;
  // otherwise steps are random and overlaps are common.
  task automatic send_chain(int len, longint hw_mask, bit tight);
    longint hw;
    longint prev_hw;
    longint step;
    bit     open;
    open    = ($urandom_range(7) != 0);
    prev_hw = 0;
    if (tight) begin
      cur_center = CenterMin + $urandom_range(0, 1000);
    end else begin
      cur_center = longint'($signed($urandom));
    end
    for (int i = 0; i < len; i++) begin
      hw = longint'($urandom) & hw_mask;
      if (i > 0) begin
        if (tight) begin
          step = prev_hw + hw + $urandom_range(0, 1);
        end else if ($urandom_range(3) == 0) begin
          step = prev_hw + hw;
        end else begin
          step = longint'($urandom) & (2 * hw_mask + 1);
        end
        cur_center += step;
        if (cur_center > CenterMax) begin
          cur_center = CenterMax;
        end
      end
      send_interval(open && (i == 0), cur_center, hw);
      prev_hw = hw;
    end
  endtask

  initial begin
    longint masks[5];
    int     phase_end;
    int     pick;
    masks = '{64'h0, 64'hF, 64'hFFFF, 64'hFF_FFFF, 64'h7FFF_FFFF};

    in_if.valid      = 1'b0;
    in_if.start_req  = 1'b0;
    in_if.center     = '0;
    in_if.half_width = '0;
    out_if.ready     = 1'b0;
    src_idle_pct     = 15;
    snk_idle_pct     = 59;
    sent             = 0;
    starts           = 0;
    rst_ni           = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme ends: the lowest center, then the widest interval around it.
    send_interval(1'b1, CenterMin, 0);
    send_interval(1'b0, CenterMin, HalfMax);
    // Touching intervals grow the chain; a narrow one then lowers an end.
    send_interval(1'b1, 0, 5);
    send_interval(1'b0, 10, 5);
    send_interval(1'b0, 20, 5);
    send_interval(1'b0, 21, 0);
    // Highest center with the widest and the zero half width.
    send_interval(1'b0, CenterMax, HalfMax);
    send_interval(1'b0, CenterMax, 0);
    // Centers out of order are taken as they come.
    send_interval(1'b0, -100, 1);
    send_interval(1'b0, -100, 1);
    send_interval(1'b0, CenterMin, 0);
    // Fresh start on the widest interval, repeated.
    send_interval(1'b1, CenterMax, HalfMax);
    send_interval(1'b0, CenterMax, HalfMax);
    // Zero-width points that touch each other.
    send_interval(1'b1, -1, 0);
    send_interval(1'b0, 0, 0);
    send_interval(1'b0, 1, 0);
    send_interval(1'b0, 1, 0);
    send_interval(1'b1, 7, 7);
    wait_drained();

    // Three idling mixes; the sender drains the block between them.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 15;
          snk_idle_pct = 59;
        end
        1: begin
          src_idle_pct = 59;
          snk_idle_pct = 15;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      phase_end = 370 + phase * 340;
      // The first mix always overruns the table capacity once.
      if (phase == 0) begin
        send_chain(MaxChain + 14, 3, 1'b1);
      end
      while (sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          send_chain($urandom_range(1, 30), masks[$urandom_range(4)], 1'b0);
        end else if (pick < 83) begin
          send_chain($urandom_range(20, 60), 3, 1'b1);
        end else if (pick < 85) begin
          send_chain(MaxChain + $urandom_range(1, 8), 1, 1'b1);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_interval($urandom_range(15) == 0, longint'($signed($urandom)),
                          longint'($urandom) & HalfMax);
          end
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d intervals, %0d of them opening a new chain, in three stall mixes.",
             sent, starts);
    $display("%0d results compared, %0d of them flagging a chain dropped at capacity.",
             checked, cap_seen);
    if (fail_count == 0) begin
      $display("** interval_chain_length_dp: PASSED **");
    end else begin
      $display("** interval_chain_length_dp: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding.", pending);
    $display("** interval_chain_length_dp: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/icl_pkg.sv
rtl/icl_if.sv
rtl/icl_cell.sv
rtl/icl_chain.sv
rtl/interval_chain_length_dp.sv
dv/icl_chain_checker.sv
dv/tb_top.sv
